// ----- design/chc_pkg.sv -----
// Shared constants and types of the calorimeter hit clusterer.
package chc_pkg;
   localparam int MaxClustersDefault = 64;
   localparam int CellBitsDefault = 10;
   localparam int TimeBits = 32;
   localparam int EnergyBits = 24;
   localparam int WindowBits = 16;
   localparam int CountBits = 8;
   localparam int IndexBits = 6;
   localparam int CsrDataBits = 24;
   localparam logic [1:0] CSR_WINDOW = 2'd0;
   localparam logic [1:0] CSR_HIGH = 2'd1;
   localparam logic [1:0] CSR_LOW = 2'd2;
   localparam logic [EnergyBits-1:0] EnergyMax = '1;
   localparam logic [CountBits-1:0] CountMax = '1;

   typedef struct packed {
      logic load;      // capture request word
      logic rd_en;     // read slot at rd_addr
      logic wr_new;    // write new cluster at fill count
      logic wr_merge;  // write merged cluster at found slot
      logic set_ovf;
      logic clear;     // empty table
      logic found_clr;
      logic arm_clr;
      logic emit;      // load output register from read data
      logic last;
   } chc_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic cell_match;
      logic gap_ok;
      logic full;
      logic found;
      logic armed;
      logic keep;
      logic high_hit;
   } chc_sts_type;
endpackage

// ----- design/chc_datapath.sv -----
// Cluster table, hit merge arithmetic and output register.
module chc_datapath import chc_pkg::*; #(
   parameter int MAX_CLUSTERS = MaxClustersDefault,
   parameter int CELL_BITS = CellBitsDefault,
   localparam int AW = $clog2(MAX_CLUSTERS),
   localparam int NW = $clog2(MAX_CLUSTERS + 1)
) (
   input  logic clock,
   input  logic reset,
   input  chc_cmd_type cmd,
   output chc_sts_type sts,
   input  logic [AW-1:0] rd_addr,
   output logic [NW-1:0] used,
   input  logic [WindowBits-1:0] window,
   input  logic [EnergyBits-1:0] high_thr,
   input  logic [EnergyBits-1:0] low_thr,
   input  logic req_action,
   input  logic [CELL_BITS-1:0] req_cell_id,
   input  logic [TimeBits-1:0] req_hit_time,
   input  logic [EnergyBits-1:0] req_hit_energy,
   input  logic req_is_primary,
   input  logic [2:0] req_particle_kind,
   output logic [IndexBits-1:0] o_index,
   output logic [CELL_BITS-1:0] o_cell,
   output logic [TimeBits-1:0] o_time,
   output logic [EnergyBits-1:0] o_energy,
   output logic [5*CountBits-1:0] o_counts,
   output logic o_ovf,
   output logic o_last
);
   localparam int SW = CELL_BITS + TimeBits + EnergyBits + 5 * CountBits;
   logic [SW-1:0] mem [MAX_CLUSTERS];
   logic [SW-1:0] rd_ff;
   logic [AW-1:0] rd_addr_ff;
   logic h_action_ff, h_prim_ff;
   logic [CELL_BITS-1:0] h_cell_ff;
   logic [TimeBits-1:0] h_time_ff;
   logic [EnergyBits-1:0] h_energy_ff;
   logic [2:0] h_lane_ff;
   logic [NW-1:0] used_ff;
   logic ovf_ff, found_ff, armed_ff;
   logic [AW-1:0] found_addr_ff;
   logic [CELL_BITS-1:0] r_cell;
   logic [TimeBits-1:0] r_time, gap;
   logic [EnergyBits-1:0] r_energy, m_energy;
   logic [5*CountBits-1:0] r_counts, m_counts, n_counts;
   logic [TimeBits-1:0] m_time;
   logic [EnergyBits:0] esum;

   assign {r_cell, r_time, r_energy, r_counts} = rd_ff;
   assign gap = (h_time_ff >= r_time) ? h_time_ff - r_time : r_time - h_time_ff;
   assign esum = {1'b0, r_energy} + {1'b0, h_energy_ff};
   assign m_energy = esum[EnergyBits] ? EnergyMax : esum[EnergyBits-1:0];
   assign m_time = (h_time_ff < r_time) ? h_time_ff : r_time;

   always_comb begin
      m_counts = r_counts;
      n_counts = '0;
      for (int j = 0; j < 5; j++) begin
         if (h_prim_ff && h_lane_ff == 3'(j)) begin
            n_counts[j*CountBits +: CountBits] = CountBits'(1);
            if (r_counts[j*CountBits +: CountBits] != CountMax) begin
               m_counts[j*CountBits +: CountBits] =
                  r_counts[j*CountBits +: CountBits] + CountBits'(1);
            end
         end
      end
   end

   assign used = used_ff;
   assign sts.is_flush = h_action_ff;
   assign sts.cell_match = (r_cell == h_cell_ff);
   assign sts.gap_ok = (gap <= {{(TimeBits-WindowBits){1'b0}}, window});
   assign sts.full = (used_ff >= NW'(MAX_CLUSTERS));
   assign sts.found = found_ff;
   assign sts.armed = armed_ff;
   assign sts.keep = (r_energy >= low_thr);
   assign sts.high_hit = (r_energy >= high_thr);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.wr_new) begin
         mem[used_ff[AW-1:0]] <= {h_cell_ff, h_time_ff, h_energy_ff, n_counts};
      end else if (cmd.wr_merge) begin
         mem[found_addr_ff] <= {r_cell, m_time, m_energy, m_counts};
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      if (cmd.load) begin
         h_action_ff <= req_action;
         h_cell_ff <= req_cell_id;
         h_time_ff <= req_hit_time;
         h_energy_ff <= req_hit_energy;
         h_prim_ff <= req_is_primary;
         h_lane_ff <= (req_particle_kind <= 3'd3) ? req_particle_kind : 3'd4;
      end
      if (cmd.emit) begin
         o_index <= IndexBits'(rd_addr_ff);
         o_cell <= r_cell;
         o_time <= r_time;
         o_energy <= r_energy;
         o_counts <= r_counts;
         o_ovf <= ovf_ff;
         o_last <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         used_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         if (cmd.wr_new) used_ff <= used_ff + NW'(1);
         if (cmd.set_ovf) ovf_ff <= 1'b1;
      end
      if (reset || cmd.found_clr) begin
         found_ff <= 1'b0;
      end else if (cmd.last && !h_action_ff && !found_ff && sts.cell_match) begin
         found_ff <= 1'b1;
         found_addr_ff <= rd_addr_ff;
      end
      if (reset || cmd.arm_clr) begin
         armed_ff <= 1'b0;
      end else if (cmd.last && h_action_ff && sts.high_hit) begin
         armed_ff <= 1'b1;
      end
   end
endmodule

// ----- design/chc_ctrl.sv -----
// Sequencer for table search, merge, trigger scan and emission.
module chc_ctrl import chc_pkg::*; #(
   parameter int MAX_CLUSTERS = MaxClustersDefault,
   localparam int AW = $clog2(MAX_CLUSTERS),
   localparam int NW = $clog2(MAX_CLUSTERS + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  chc_sts_type sts,
   input  logic [NW-1:0] used,
   output chc_cmd_type cmd,
   output logic [AW-1:0] rd_addr
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_SRCH = 3'd2;   // newest first, one slot per cycle
   localparam logic [2:0] S_DEC = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;   // trigger scan
   localparam logic [2:0] S_EMIT = 3'd5;   // ordered emission

   logic [2:0] state_ff, state_in;
   logic [NW-1:0] ptr_ff, ptr_in;       // slots still to visit
   logic chk_ff, chk_in;                // read data belongs to a visited slot
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] lastk_ff, lastk_in;   // highest slot at or above low threshold
   logic outv_ff, outv_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = outv_ff;
   assign rd_addr = addr_in;

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      chk_in = 1'b0;
      addr_in = addr_ff;
      lastk_in = lastk_ff;
      outv_in = outv_ff;
      cmd = '0;
      if (outv_ff && rsp_ready) outv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               cmd.found_clr = 1'b1;
               cmd.arm_clr = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            ptr_in = used;
            if (used == '0) begin
               state_in = sts.is_flush ? S_IDLE : S_DEC;
               if (sts.is_flush) cmd.clear = 1'b1;
            end else begin
               addr_in = sts.is_flush ? '0 : AW'(used - NW'(1));
               cmd.rd_en = 1'b1;
               chk_in = 1'b1;
               ptr_in = used - NW'(1);
               state_in = sts.is_flush ? S_SCAN : S_SRCH;
            end
         end
         S_SRCH: begin
            cmd.last = chk_ff;
            if (chk_ff && sts.cell_match) begin
               state_in = S_DEC;
               cmd.rd_en = 1'b1;  // reread found slot for merge
            end else if (ptr_ff == '0) begin
               state_in = S_DEC;
            end else begin
               addr_in = addr_ff - AW'(1);
               cmd.rd_en = 1'b1;
               chk_in = 1'b1;
               ptr_in = ptr_ff - NW'(1);
            end
         end
         S_DEC: begin
            if (sts.found && sts.gap_ok) begin
               cmd.wr_merge = 1'b1;
            end else if (sts.full) begin
               cmd.set_ovf = 1'b1;
            end else begin
               cmd.wr_new = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            cmd.last = chk_ff;
            if (chk_ff && sts.keep) lastk_in = addr_ff;
            if (ptr_ff == '0) begin
               if (sts.armed || (chk_ff && sts.high_hit)) begin
                  addr_in = '0;
                  cmd.rd_en = 1'b1;
                  ptr_in = used - NW'(1);
                  state_in = S_EMIT;
               end else begin
                  cmd.clear = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               addr_in = addr_ff + AW'(1);
               cmd.rd_en = 1'b1;
               chk_in = 1'b1;
               ptr_in = ptr_ff - NW'(1);
            end
         end
         S_EMIT: begin
            // read data is slot addr_ff; hold while the output word is still waiting
            if (!outv_in) begin
               if (sts.keep) begin
                  cmd.emit = 1'b1;
                  cmd.last = (addr_ff == lastk_ff);
                  outv_in = 1'b1;
               end
               if (ptr_ff == '0) begin
                  cmd.clear = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  addr_in = addr_ff + AW'(1);
                  cmd.rd_en = 1'b1;
                  ptr_in = ptr_ff - NW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff <= '0;
         chk_ff <= 1'b0;
         addr_ff <= '0;
         lastk_ff <= '0;
         outv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         chk_ff <= chk_in;
         addr_ff <= addr_in;
         lastk_ff <= lastk_in;
         outv_ff <= outv_in;
      end
   end
endmodule

// ----- design/calorimeter_hit_clusterer.sv -----
// Top level of the calorimeter hit clusterer. A request word with action 0 is a hit: the
// cluster table is searched newest first for a cluster on the same cell, one slot per cycle;
// a hit within the time window merges into it (earliest time, saturating energy sum,
// saturating count per particle kind for primary hits), otherwise it opens a new cluster,
// or, with the table full, is dropped and raises the overflow flag. A request word with
// action 1 flushes: a scan over the table arms the trigger when any cluster reaches the high
// threshold, and then every cluster at or above the low threshold leaves in creation order
// as one response word, the final one marked last; every flush empties the table. The
// search of a hit stops at the newest cluster on the cell, visiting at most MAX_CLUSTERS
// slots. A flush scans every stored cluster and, once armed, makes an emission pass over
// them, each emission stretched while the previous response word waits on rsp_ready. A
// waiting response word does not hold off the next request word. Registers: index 0
// cluster window, 1 high threshold, 2 low threshold.
module calorimeter_hit_clusterer import chc_pkg::*; #(
   parameter int MAX_CLUSTERS = MaxClustersDefault,
   parameter int CELL_BITS = CellBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [CsrDataBits-1:0] csr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_action,
   input  logic [CELL_BITS-1:0] req_cell_id,
   input  logic [TimeBits-1:0] req_hit_time,
   input  logic [EnergyBits-1:0] req_hit_energy,
   input  logic req_is_primary,
   input  logic [2:0] req_particle_kind,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [IndexBits-1:0] rsp_cluster_index,
   output logic [CELL_BITS-1:0] rsp_out_cell,
   output logic [TimeBits-1:0] rsp_out_time,
   output logic [EnergyBits-1:0] rsp_out_energy,
   output logic [CountBits-1:0] rsp_n_electron,
   output logic [CountBits-1:0] rsp_n_positron,
   output logic [CountBits-1:0] rsp_n_gamma,
   output logic [CountBits-1:0] rsp_n_alpha,
   output logic [CountBits-1:0] rsp_n_other,
   output logic rsp_overflowed,
   output logic rsp_last
);
   localparam int AW = $clog2(MAX_CLUSTERS);
   localparam int NW = $clog2(MAX_CLUSTERS + 1);
   chc_cmd_type cmd;
   chc_sts_type sts;
   logic [AW-1:0] rd_addr;
   logic [NW-1:0] used;
   logic [5*CountBits-1:0] counts;
   logic [WindowBits-1:0] window_ff;
   logic [EnergyBits-1:0] high_ff, low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WindowBits'(1000);
         high_ff <= EnergyBits'(150);
         low_ff <= EnergyBits'(50);
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW: window_ff <= csr_data[WindowBits-1:0];
            CSR_HIGH: high_ff <= csr_data;
            CSR_LOW: low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   chc_ctrl #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .used, .cmd, .rd_addr
   );

   chc_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS), .CELL_BITS(CELL_BITS)) u_dp (
      .clock, .reset, .cmd, .sts, .rd_addr, .used,
      .window(window_ff), .high_thr(high_ff), .low_thr(low_ff),
      .req_action, .req_cell_id, .req_hit_time, .req_hit_energy,
      .req_is_primary, .req_particle_kind,
      .o_index(rsp_cluster_index), .o_cell(rsp_out_cell), .o_time(rsp_out_time),
      .o_energy(rsp_out_energy), .o_counts(counts), .o_ovf(rsp_overflowed),
      .o_last(rsp_last)
   );

   assign {rsp_n_other, rsp_n_alpha, rsp_n_gamma, rsp_n_positron, rsp_n_electron} = counts;
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the calorimeter hit clusterer.
module tb_top;
   import chc_pkg::*;

   localparam int NumSlots = MaxClustersDefault;
   localparam int CycleLimit = 3000000;
   localparam logic ActHit = 1'b0;
   localparam logic ActFlush = 1'b1;
   localparam logic [2:0] KindElectron = 3'd0;
   localparam logic [2:0] KindPositron = 3'd1;
   localparam logic [2:0] KindGamma = 3'd2;
   localparam logic [2:0] KindAlpha = 3'd3;
   localparam logic [2:0] KindOther = 3'd4;

   // One emitted cluster as it leaves the block.
   typedef struct packed {
      logic [IndexBits-1:0] index;
      logic [9:0] cell_no;
      logic [TimeBits-1:0] t;
      logic [EnergyBits-1:0] energy;
      logic [4:0][CountBits-1:0] counts;
      logic ovf;
      logic last;
   } cluster_word_type;

   // Cluster table predictor and store of pending clusters.
   class cluster_board_type;
      logic [15:0] window;
      logic [EnergyBits-1:0] thr_high, thr_low;
      logic [9:0] cell_q [NumSlots];
      logic [TimeBits-1:0] time_q [NumSlots];
      logic [EnergyBits-1:0] energy_q [NumSlots];
      logic [4:0][CountBits-1:0] count_q [NumSlots];
      int used;
      bit ovf;
      cluster_word_type pending [$];
      int errors;

      function void clear_all();
         window = 16'd1000;
         thr_high = 24'd150;
         thr_low = 24'd50;
         used = 0;
         ovf = 0;
         errors = 0;
         pending.delete();
      endfunction

      function void set_reg(logic [1:0] idx, logic [CsrDataBits-1:0] val);
         case (idx)
            CSR_WINDOW: window = val[15:0];
            CSR_HIGH: thr_high = val;
            CSR_LOW: thr_low = val;
            default: ;
         endcase
      endfunction

      // Note an accepted request word and queue the clusters it releases.
      function void note_request(logic act, logic [9:0] cell_no, logic [31:0] t,
                                 logic [23:0] e, logic prim, logic [2:0] kind);
         int hit_slot;
         int lane;
         logic [31:0] gap;
         logic [24:0] sum;
         bit armed;
         int last_pos;
         cluster_word_type w;
         hit_slot = -1;
         lane = (kind <= 3) ? kind : 4;
         if (act == ActFlush) begin
            armed = 0;
            last_pos = -1;
            for (int i = 0; i < used; i++)
               if (energy_q[i] >= thr_high) armed = 1;
            if (armed) begin
               for (int i = 0; i < used; i++) begin
                  if (energy_q[i] < thr_low) continue;
                  w.index = IndexBits'(i);
                  w.cell_no = cell_q[i];
                  w.t = time_q[i];
                  w.energy = energy_q[i];
                  w.counts = count_q[i];
                  w.ovf = ovf;
                  w.last = 0;
                  pending = {pending, w};
                  last_pos = pending.size() - 1;
               end
               if (last_pos >= 0) pending[last_pos].last = 1;
            end
            used = 0;
            ovf = 0;
            return;
         end
         // Search newest first for a cluster on this cell.
         for (int i = used - 1; i >= 0; i--)
            if (cell_q[i] == cell_no) begin
               hit_slot = i;
               break;
            end
         if (hit_slot >= 0) begin
            gap = (t >= time_q[hit_slot]) ? t - time_q[hit_slot] : time_q[hit_slot] - t;
            if (gap <= window) begin
               sum = {1'b0, energy_q[hit_slot]} + {1'b0, e};
               if (t < time_q[hit_slot]) time_q[hit_slot] = t;
               energy_q[hit_slot] = sum[24] ? EnergyMax : sum[23:0];
               if (prim && count_q[hit_slot][lane] != CountMax)
                  count_q[hit_slot][lane] = count_q[hit_slot][lane] + CountBits'(1);
               return;
            end
         end
         if (used >= NumSlots) begin
            ovf = 1;
            return;
         end
         cell_q[used] = cell_no;
         time_q[used] = t;
         energy_q[used] = e;
         count_q[used] = '0;
         if (prim) count_q[used][lane] = CountBits'(1);
         used++;
      endfunction

      function void check_cluster(cluster_word_type got);
         cluster_word_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected cluster word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("cluster mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [1:0] csr_index = '0;
   logic [CsrDataBits-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic req_action = 0;
   logic [9:0] req_cell_id = '0;
   logic [TimeBits-1:0] req_hit_time = '0;
   logic [EnergyBits-1:0] req_hit_energy = '0;
   logic req_is_primary = 0;
   logic [2:0] req_particle_kind = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [IndexBits-1:0] rsp_cluster_index;
   logic [9:0] rsp_out_cell;
   logic [TimeBits-1:0] rsp_out_time;
   logic [EnergyBits-1:0] rsp_out_energy;
   logic [CountBits-1:0] rsp_n_electron, rsp_n_positron, rsp_n_gamma;
   logic [CountBits-1:0] rsp_n_alpha, rsp_n_other;
   logic rsp_overflowed, rsp_last;

   cluster_board_type board;
   int cycles = 0;
   int stall_long = 0;   // cycles the receiver still holds off

   calorimeter_hit_clusterer dut (.*);

   always #5 clock = ~clock;

   // Abort the run at a generous cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: a randomly drawn wait after each word, plus one long hold-off on request.
   initial begin
      int wait_n;
      wait_n = 0;
      board = new();
      board.clear_all();
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_cluster({rsp_cluster_index, rsp_out_cell, rsp_out_time,
               rsp_out_energy, rsp_n_other, rsp_n_alpha, rsp_n_gamma,
               rsp_n_positron, rsp_n_electron, rsp_overflowed, rsp_last});
         if (stall_long > 0) begin
            stall_long <= stall_long - 1;
            rsp_ready <= 0;
         end else if (rsp_valid && rsp_ready) begin
            wait_n = $urandom_range(0, 4);
            rsp_ready <= (wait_n == 0);
         end else if (!rsp_ready) begin
            if (wait_n > 0) wait_n--;
            if (wait_n == 0) rsp_ready <= 1;
         end
      end
   end

   // Offer one request word and hold it until accepted.
   task automatic send_word(logic act, logic [9:0] cell_no, logic [31:0] t,
                            logic [23:0] e, logic prim, logic [2:0] kind);
      int gap_n;
      gap_n = $urandom_range(0, 4);
      if ($urandom_range(0, 4) == 0) gap_n = 0;
      if (gap_n > 0) begin
         req_valid <= 0;
         repeat (gap_n) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_cell_id <= cell_no;
      req_hit_time <= t;
      req_hit_energy <= e;
      req_is_primary <= prim;
      req_particle_kind <= kind;
      do @(posedge clock); while (!req_ready);
      board.note_request(act, cell_no, t, e, prim, kind);
   endtask

   task automatic send_hit(logic [9:0] cell_no, logic [31:0] t, logic [23:0] e,
                           logic prim, logic [2:0] kind);
      send_word(ActHit, cell_no, t, e, prim, kind);
   endtask

   task automatic send_flush();
      send_word(ActFlush, 10'($urandom), $urandom, 24'($urandom), 1'($urandom),
         3'($urandom));
   endtask

   // Drop valid, wait for the block to drain, then let the clock run on idle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CsrDataBits-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      csr_write <= 0;
      @(posedge clock);
   endtask

   // A random event: a burst of hits on a few cells, then a flush.
   task automatic random_event(int n_hits, int n_cells);
      logic [9:0] base;
      logic [31:0] t0;
      base = 10'($urandom);
      t0 = $urandom;
      for (int i = 0; i < n_hits; i++)
         if ($urandom_range(0, 9) == 0)
            send_hit(10'($urandom), $urandom, 24'($urandom), 1'($urandom),
               3'($urandom));
         else
            send_hit(10'(base + $urandom_range(0, n_cells - 1)),
               t0 + $urandom_range(0, 2 * board.window + 2),
               24'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300)),
               1'($urandom), 3'($urandom_range(0, 7)));
      send_flush();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: merge, window edge, saturation, kinds, no-trigger flush.
      send_hit(10'd0, 32'd0, 24'd100, 1'b1, KindElectron);
      send_hit(10'd0, 32'd1000, 24'd100, 1'b1, KindPositron);
      send_hit(10'd0, 32'd2001, 24'd60, 1'b1, KindGamma);
      send_hit(10'd1023, 32'hFFFF_FFFF, EnergyMax, 1'b1, KindAlpha);
      send_hit(10'd1023, 32'hFFFF_FFF0, EnergyMax, 1'b1, KindOther);
      send_hit(10'd5, 32'd50, 24'd49, 1'b0, 3'd7);
      send_hit(10'd6, 32'd50, 24'd50, 1'b1, 3'd5);
      send_hit(10'd7, 32'd50, 24'd0, 1'b1, 3'd6);
      send_flush();
      send_hit(10'd3, 32'd0, 24'd149, 1'b1, KindElectron);
      send_flush();
      send_flush();
      send_hit(10'd3, 32'd0, 24'd150, 1'b1, KindElectron);
      send_flush();
      // Saturate a count: 260 primary electron hits on one cell.
      for (int i = 0; i < 260; i++) send_hit(10'd9, 32'd7, 24'd1, 1'b1, KindElectron);
      send_flush();
      drain();

      // Fill the table past full, then flush while the receiver holds off.
      write_reg(CSR_WINDOW, 24'd0);
      write_reg(CSR_HIGH, 24'd0);
      write_reg(CSR_LOW, 24'd0);
      for (int i = 0; i < NumSlots + 4; i++)
         send_hit(10'(i), 32'd5, 24'($urandom), 1'b0, KindElectron);
      send_hit(10'd0, 32'd5, 24'd1, 1'b1, KindOther);
      stall_long <= 400;
      send_flush();
      send_hit(10'd1, 32'd0, 24'd1, 1'b0, KindElectron);
      send_flush();
      drain();

      // Random phases across several register settings.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_WINDOW, 24'd1000); write_reg(CSR_HIGH, 24'd150);
               write_reg(CSR_LOW, 24'd50); end
            1: begin write_reg(CSR_WINDOW, 24'hFFFF); write_reg(CSR_HIGH, EnergyMax);
               write_reg(CSR_LOW, EnergyMax); end
            2: begin write_reg(CSR_WINDOW, 24'd20); write_reg(CSR_HIGH, 24'd200);
               write_reg(CSR_LOW, 24'd0); end
            default: begin write_reg(CSR_WINDOW, 24'($urandom_range(0, 2000)));
               write_reg(CSR_HIGH, 24'($urandom_range(0, 400)));
               write_reg(CSR_LOW, 24'($urandom_range(0, 200))); end
         endcase
         for (int ev = 0; ev < 2; ev++) begin
            int h;
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
            random_event(h, $urandom_range(1, 6));
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- calorimeter_hit_clusterer.f -----
design/chc_pkg.sv
design/chc_datapath.sv
design/chc_ctrl.sv
design/calorimeter_hit_clusterer.sv
tb/sv/tb_top.sv
